// File: hw/rtl/mfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfc_pkg;

	// Encoder and round counter geometry
	localparam int ENC_W          = 13;
	localparam int ENCODER_COUNTS = 1 << ENC_W;
	localparam int ROUND_BITS     = 24;
	localparam int TOTAL_W        = ROUND_BITS + ENC_W;

	localparam logic signed [ROUND_BITS-1:0] ROUND_MAX = {1'b0, {(ROUND_BITS-1){1'b1}}};
	localparam logic signed [ROUND_BITS-1:0] ROUND_MIN = {1'b1, {(ROUND_BITS-1){1'b0}}};

	// Field widths
	localparam int RPM_W    = 16;
	localparam int CUR_W    = 16;
	localparam int TORQUE_W = 32;
	localparam int SUM_W    = TORQUE_W + 1;
	localparam int ANGLE_W  = 48;
	localparam int SPEED_W  = 32;
	localparam int DRIVE_W  = 16;

	// Configuration registers
	localparam int ANGLE_SCALE_W  = 24;
	localparam int SPEED_SCALE_W  = 18;
	localparam int TORQUE_SCALE_W = 24;
	localparam int CMD_SCALE_W    = 28;
	localparam int LIFT_W         = 15;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 28;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_LIFT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_LIMIT = 3'd5;

	localparam logic [ANGLE_SCALE_W-1:0]  ANGLE_SCALE_RST  = 24'd823550;
	localparam logic [SPEED_SCALE_W-1:0]  SPEED_SCALE_RST  = 18'd6862;
	localparam logic [TORQUE_SCALE_W-1:0] TORQUE_SCALE_RST = 24'd1536;
	localparam logic [CMD_SCALE_W-1:0]    CMD_SCALE_RST    = 28'd53687091;
	localparam logic [LIFT_W-1:0]         LIFT_RST         = 15'd0;
	localparam logic [LIFT_W-1:0]         LIMIT_RST        = 15'd16384;

	typedef enum logic [1:0] {
		MODE_FRAME = 2'd0,
		MODE_CMD   = 2'd1,
		MODE_ALIVE = 2'd2
	} mode_t;

	// Per-item data that rides alongside the multipliers
	typedef struct packed {
		logic [1:0]                    mode;
		logic                          angle_neg;
		logic                          cmd_neg;
		logic signed [SPEED_W-1:0]     speed;
		logic signed [TORQUE_W-1:0]    torque;
		logic signed [ROUND_BITS-1:0]  turns;
		logic                          online;
	} side_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfc_unwrap.sv
`timescale 1ns / 1ps
`default_nettype none

module mfc_unwrap (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   take,
	input  wire logic [1:0]                             mode,
	input  wire logic [mfc_pkg::ENC_W-1:0]              encoder,
	output logic signed [mfc_pkg::TOTAL_W-1:0]          total,
	output logic signed [mfc_pkg::ROUND_BITS-1:0]       turns,
	output logic                                        online
);

	localparam logic signed [mfc_pkg::ENC_W:0] HALF_TURN =
		(mfc_pkg::ENC_W+1)'(mfc_pkg::ENCODER_COUNTS / 2);

	logic [mfc_pkg::ENC_W-1:0]               prev_q;
	logic signed [mfc_pkg::ROUND_BITS-1:0]   round_q;
	logic signed [mfc_pkg::ROUND_BITS-1:0]   round_nxt;
	logic                                    frame_seen_q;
	logic                                    online_q;
	logic signed [mfc_pkg::ENC_W:0]          delta;
	logic                                    is_frame;
	logic                                    is_alive;

	assign is_frame = (mode == mfc_pkg::MODE_FRAME);
	assign is_alive = (mode == mfc_pkg::MODE_ALIVE);
	assign delta    = $signed({1'b0, encoder}) - $signed({1'b0, prev_q});

	// backward jump of over half a turn: wrapped forwards, and vice versa
	always_comb begin
		round_nxt = round_q;
		if (delta < -HALF_TURN) begin
			if (round_q != mfc_pkg::ROUND_MAX)
				round_nxt = round_q + mfc_pkg::ROUND_BITS'(1);
		end else if (delta > HALF_TURN) begin
			if (round_q != mfc_pkg::ROUND_MIN)
				round_nxt = round_q - mfc_pkg::ROUND_BITS'(1);
		end
	end

	// the encoder field spans exactly one turn, so rounds and position concatenate
	assign total  = $signed({round_nxt, encoder});
	assign turns  = is_frame ? round_nxt : round_q;
	assign online = is_alive ? frame_seen_q : online_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			round_q      <= '0;
			frame_seen_q <= 1'b0;
			online_q     <= 1'b0;
		end else if (take) begin
			if (is_frame) begin
				prev_q       <= encoder;
				round_q      <= round_nxt;
				frame_seen_q <= 1'b1;
			end else if (is_alive) begin
				online_q     <= frame_seen_q;
				frame_seen_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mfc_split_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned multiply in two stages: two narrow partial products, then their sum.
// Stage numbers below are local to this unit.
module mfc_split_mul #(
	parameter int AW = 37,
	parameter int BW = 24,
	parameter int LW = 18
) (
	input  wire logic             clk,
	input  wire logic             en_pp,
	input  wire logic             en_sum,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic [AW+BW-1:0]      prod
);

	localparam int HW = AW - LW;

	logic [LW+BW-1:0] pp_lo_s1;
	logic [HW+BW-1:0] pp_hi_s1;
	logic [AW+BW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en_pp) begin
			pp_lo_s1 <= (LW+BW)'(a[LW-1:0] * b);
			pp_hi_s1 <= (HW+BW)'(a[AW-1:LW] * b);
		end
		if (en_sum)
			prod_s2 <= {pp_hi_s1, {LW{1'b0}}} + (AW+BW)'(pp_lo_s1);
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

// File: hw/rtl/motor_feedback_and_command_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Motor feedback and drive command unit.
// Input channel (in_valid/in_ready) carries one transaction per item: a feedback
// frame (mode 0), a command tick (mode 1) or an alive tick (mode 2); mode 3 is a
// no-op. Every accepted transaction yields exactly one output transaction
// (out_valid/out_ready) carrying all held values: multi-turn angle, speed, torque,
// drive count, online flag and round count.
// One transaction per clock is sustained while out_ready stays high. The path runs
// through an input register, unwrap/sum, magnitude/saturate, two multiplier stages
// (partial products, then sum) and the output register that also holds the values.
// When the receiver stalls, up to six transactions are held in the pipeline
// stages; in_ready drops only once all are full.
// Reset (arst_n low, asynchronous) loads the default scales, clears round count
// and held outputs to zero and reports offline. The cfg port must be written
// only while no transaction is in flight; the block itself does not enforce this.
module motor_feedback_and_command_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           mode,
	input  wire logic [mfc_pkg::ENC_W-1:0]            encoder_raw,
	input  wire logic signed [mfc_pkg::RPM_W-1:0]     speed_rpm,
	input  wire logic signed [mfc_pkg::CUR_W-1:0]     current_raw,
	input  wire logic signed [mfc_pkg::TORQUE_W-1:0]  torque_setpoint,
	input  wire logic signed [mfc_pkg::TORQUE_W-1:0]  torque_ffwd,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [mfc_pkg::ANGLE_W-1:0]        multi_turn_angle,
	output logic signed [mfc_pkg::SPEED_W-1:0]        angular_speed,
	output logic signed [mfc_pkg::TORQUE_W-1:0]       measured_torque,
	output logic signed [mfc_pkg::DRIVE_W-1:0]        drive_count,
	output logic                                      online,
	output logic signed [mfc_pkg::ROUND_BITS-1:0]     turns,
	input  wire logic                                 cfg_we,
	input  wire logic [mfc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SPEED_P_W    = mfc_pkg::RPM_W + mfc_pkg::SPEED_SCALE_W + 1;
	localparam int TORQUE_P_W   = mfc_pkg::CUR_W + mfc_pkg::TORQUE_SCALE_W + 1;
	localparam int ANGLE_PROD_W = mfc_pkg::TOTAL_W + mfc_pkg::ANGLE_SCALE_W;
	localparam int CMD_PROD_W   = mfc_pkg::SUM_W + mfc_pkg::CMD_SCALE_W;
	localparam int CMD_INT_W    = CMD_PROD_W - 32;

	localparam logic signed [31:0] SAT_MAX = {1'b0, {31{1'b1}}};
	localparam logic signed [31:0] SAT_MIN = {1'b1, {31{1'b0}}};

	// configuration
	logic [mfc_pkg::ANGLE_SCALE_W-1:0]  angle_scale_q;
	logic [mfc_pkg::SPEED_SCALE_W-1:0]  speed_scale_q;
	logic [mfc_pkg::TORQUE_SCALE_W-1:0] torque_scale_q;
	logic [mfc_pkg::CMD_SCALE_W-1:0]    cmd_scale_q;
	logic [mfc_pkg::LIFT_W-1:0]         lift_q;
	logic [mfc_pkg::LIFT_W-1:0]         limit_q;

	// stage valids and enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	logic en2, en3, en4, en5, en_o;

	// s1: input register
	logic [1:0]                             mode_s1;
	logic [mfc_pkg::ENC_W-1:0]              encoder_s1;
	logic signed [mfc_pkg::RPM_W-1:0]       rpm_s1;
	logic signed [mfc_pkg::CUR_W-1:0]       current_s1;
	logic signed [mfc_pkg::TORQUE_W-1:0]    target_s1;
	logic signed [mfc_pkg::TORQUE_W-1:0]    feedfwd_s1;

	// unwrap outputs
	logic signed [mfc_pkg::TOTAL_W-1:0]     total_c;
	logic signed [mfc_pkg::ROUND_BITS-1:0]  turns_c;
	logic                                   online_c;

	// s2
	logic [1:0]                             mode_s2;
	logic signed [mfc_pkg::TOTAL_W-1:0]     total_s2;
	logic signed [mfc_pkg::SUM_W-1:0]       sum_s2;
	logic signed [SPEED_P_W-1:0]            speed_p_s2;
	logic signed [TORQUE_P_W-1:0]           torque_p_s2;
	logic signed [mfc_pkg::ROUND_BITS-1:0]  turns_s2;
	logic                                   online_s2;

	// s3
	logic [mfc_pkg::TOTAL_W-1:0]            angle_mag_s3;
	logic [mfc_pkg::SUM_W-1:0]              cmd_mag_s3;
	mfc_pkg::side_t                         side_s3;
	mfc_pkg::side_t                         side_s4;
	mfc_pkg::side_t                         side_s5;

	// multiplier products, valid alongside s5
	logic [ANGLE_PROD_W-1:0]                angle_prod;
	logic [CMD_PROD_W-1:0]                  cmd_prod;

	// output stage logic
	logic [mfc_pkg::ANGLE_W-1:0]            angle_abs;
	logic signed [mfc_pkg::ANGLE_W-1:0]     angle_val;
	logic [CMD_INT_W-1:0]                   cmd_int;
	logic                                   cmd_nonzero;
	logic [CMD_INT_W:0]                     cmd_lifted;
	logic [mfc_pkg::LIFT_W-1:0]             cmd_clamped;
	logic [mfc_pkg::DRIVE_W-1:0]            drive_mag;
	logic signed [mfc_pkg::DRIVE_W-1:0]     drive_val;

	// held outputs
	logic signed [mfc_pkg::ANGLE_W-1:0]     angle_q;
	logic signed [mfc_pkg::SPEED_W-1:0]     speed_q;
	logic signed [mfc_pkg::TORQUE_W-1:0]    torque_q;
	logic signed [mfc_pkg::DRIVE_W-1:0]     drive_q;
	logic                                   online_q;
	logic signed [mfc_pkg::ROUND_BITS-1:0]  turns_q;

	// ---- configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_scale_q  <= mfc_pkg::ANGLE_SCALE_RST;
			speed_scale_q  <= mfc_pkg::SPEED_SCALE_RST;
			torque_scale_q <= mfc_pkg::TORQUE_SCALE_RST;
			cmd_scale_q    <= mfc_pkg::CMD_SCALE_RST;
			lift_q         <= mfc_pkg::LIFT_RST;
			limit_q        <= mfc_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfc_pkg::CFG_ANGLE_SCALE: begin
					angle_scale_q <= cfg_data[mfc_pkg::ANGLE_SCALE_W-1:0];
				end
				mfc_pkg::CFG_SPEED_SCALE: begin
					speed_scale_q <= cfg_data[mfc_pkg::SPEED_SCALE_W-1:0];
				end
				mfc_pkg::CFG_TORQUE_SCALE: begin
					torque_scale_q <= cfg_data[mfc_pkg::TORQUE_SCALE_W-1:0];
				end
				mfc_pkg::CFG_COMMAND_SCALE: begin
					cmd_scale_q <= cfg_data[mfc_pkg::CMD_SCALE_W-1:0];
				end
				mfc_pkg::CFG_DEADBAND_LIFT: begin
					lift_q <= cfg_data[mfc_pkg::LIFT_W-1:0];
				end
				mfc_pkg::CFG_COMMAND_LIMIT: begin
					limit_q <= cfg_data[mfc_pkg::LIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---- flow control: each stage loads when empty or when it drains
	assign en_o     = !out_valid_q || out_ready;
	assign en5      = !valid_s5 || en_o;
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign in_ready = !valid_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				valid_s3 <= valid_s2;
			if (en4)
				valid_s4 <= valid_s3;
			if (en5)
				valid_s5 <= valid_s4;
		end
	end

	// ---- s1
	always_ff @(posedge clk) begin
		if (in_ready) begin
			mode_s1    <= mode;
			encoder_s1 <= encoder_raw;
			rpm_s1     <= speed_rpm;
			current_s1 <= current_raw;
			target_s1  <= torque_setpoint;
			feedfwd_s1 <= torque_ffwd;
		end
	end

	// ---- s1 -> s2: round tracking, torque sum, speed and torque products
	mfc_unwrap u_unwrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (en2 && valid_s1),
		.mode    (mode_s1),
		.encoder (encoder_s1),
		.total   (total_c),
		.turns   (turns_c),
		.online  (online_c)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2     <= mode_s1;
			total_s2    <= total_c;
			sum_s2      <= mfc_pkg::SUM_W'(target_s1) + mfc_pkg::SUM_W'(feedfwd_s1);
			speed_p_s2  <= rpm_s1 * $signed({1'b0, speed_scale_q});
			torque_p_s2 <= current_s1 * $signed({1'b0, torque_scale_q});
			turns_s2    <= turns_c;
			online_s2   <= online_c;
		end
	end

	// ---- s2 -> s3: magnitudes and 32-bit saturation
	always_ff @(posedge clk) begin
		if (en3) begin
			angle_mag_s3 <= total_s2[mfc_pkg::TOTAL_W-1] ?
				mfc_pkg::TOTAL_W'(-total_s2) : mfc_pkg::TOTAL_W'(total_s2);
			cmd_mag_s3   <= sum_s2[mfc_pkg::SUM_W-1] ?
				mfc_pkg::SUM_W'(-sum_s2) : mfc_pkg::SUM_W'(sum_s2);
			side_s3.mode      <= mode_s2;
			side_s3.angle_neg <= total_s2[mfc_pkg::TOTAL_W-1];
			side_s3.cmd_neg   <= sum_s2[mfc_pkg::SUM_W-1];
			side_s3.turns     <= turns_s2;
			side_s3.online    <= online_s2;
			if (speed_p_s2[SPEED_P_W-1:31] != {(SPEED_P_W-31){speed_p_s2[SPEED_P_W-1]}})
				side_s3.speed <= speed_p_s2[SPEED_P_W-1] ? SAT_MIN : SAT_MAX;
			else
				side_s3.speed <= speed_p_s2[31:0];
			if (torque_p_s2[TORQUE_P_W-1:31] != {(TORQUE_P_W-31){torque_p_s2[TORQUE_P_W-1]}})
				side_s3.torque <= torque_p_s2[TORQUE_P_W-1] ? SAT_MIN : SAT_MAX;
			else
				side_s3.torque <= torque_p_s2[31:0];
		end
	end

	// ---- s3 -> s5: multipliers, side data follows
	mfc_split_mul #(
		.AW (mfc_pkg::TOTAL_W),
		.BW (mfc_pkg::ANGLE_SCALE_W),
		.LW (mfc_pkg::TOTAL_W / 2)
	) u_angle_mul (
		.clk    (clk),
		.en_pp  (en4),
		.en_sum (en5),
		.a      (angle_mag_s3),
		.b      (angle_scale_q),
		.prod   (angle_prod)
	);

	mfc_split_mul #(
		.AW (mfc_pkg::SUM_W),
		.BW (mfc_pkg::CMD_SCALE_W),
		.LW (mfc_pkg::SUM_W / 2)
	) u_cmd_mul (
		.clk    (clk),
		.en_pp  (en4),
		.en_sum (en5),
		.a      (cmd_mag_s3),
		.b      (cmd_scale_q),
		.prod   (cmd_prod)
	);

	always_ff @(posedge clk) begin
		if (en4)
			side_s4 <= side_s3;
		if (en5)
			side_s5 <= side_s4;
	end

	// ---- output stage: angle sign, drive lift / clamp / sign
	assign angle_abs = mfc_pkg::ANGLE_W'(angle_prod >> 16);
	assign angle_val = side_s5.angle_neg ? -$signed(angle_abs) : $signed(angle_abs);

	// product is Q.32 drive counts; lift applies to any nonzero value below it
	assign cmd_int     = cmd_prod[CMD_PROD_W-1:32];
	assign cmd_nonzero = (cmd_prod != '0);
	assign cmd_lifted  = (cmd_nonzero && (cmd_int < CMD_INT_W'(lift_q))) ?
		{1'b0, cmd_int} + (CMD_INT_W+1)'(lift_q) : {1'b0, cmd_int};
	assign cmd_clamped = (cmd_lifted > (CMD_INT_W+1)'(limit_q)) ?
		limit_q : cmd_lifted[mfc_pkg::LIFT_W-1:0];
	assign drive_mag   = {1'b0, cmd_clamped};
	assign drive_val   = side_s5.cmd_neg ? -$signed(drive_mag) : $signed(drive_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			angle_q     <= '0;
			speed_q     <= '0;
			torque_q    <= '0;
			drive_q     <= '0;
			online_q    <= 1'b0;
			turns_q     <= '0;
		end else if (en_o) begin
			out_valid_q <= valid_s5;
			if (valid_s5) begin
				turns_q  <= side_s5.turns;
				online_q <= side_s5.online;
				if (side_s5.mode == mfc_pkg::MODE_FRAME) begin
					angle_q  <= angle_val;
					speed_q  <= side_s5.speed;
					torque_q <= side_s5.torque;
				end
				if (side_s5.mode == mfc_pkg::MODE_CMD)
					drive_q <= drive_val;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign multi_turn_angle = angle_q;
	assign angular_speed    = speed_q;
	assign measured_torque  = torque_q;
	assign drive_count      = drive_q;
	assign online           = online_q;
	assign turns            = turns_q;

endmodule

`default_nettype wire

// File: hw/rtl/mfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfc_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [mfc_pkg::ANGLE_W-1:0]   multi_turn_angle,
	input wire logic signed [mfc_pkg::SPEED_W-1:0]   angular_speed,
	input wire logic signed [mfc_pkg::TORQUE_W-1:0]  measured_torque,
	input wire logic signed [mfc_pkg::DRIVE_W-1:0]   drive_count,
	input wire logic                                 online,
	input wire logic signed [mfc_pkg::ROUND_BITS-1:0] turns
);

	// a stalled output transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(multi_turn_angle) &&
			$stable(drive_count) && $stable(turns) && $stable(online))
		else $error("output transaction changed while stalled");

	// held values only move together with a new output transaction
	a_change_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(multi_turn_angle) || !$stable(drive_count) || !$stable(turns) ||
			!$stable(online) |-> out_valid)
		else $error("held value changed without an output transaction");

	// one frame moves the round count by at most one
	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(turns) |->
			(turns == $past(turns) + 24'sd1) || (turns == $past(turns) - 24'sd1))
		else $error("round count jumped by more than one");

	// a frame result never alters the drive count
	a_frame_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(multi_turn_angle) || !$stable(angular_speed) ||
			!$stable(measured_torque) || !$stable(turns) |-> $stable(drive_count))
		else $error("drive count changed by a feedback frame");

	// an alive tick result never alters the frame-derived values
	a_alive_only: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(online) |-> $stable(turns) && $stable(multi_turn_angle) &&
			$stable(drive_count))
		else $error("online change came with other updates");

endmodule

bind motor_feedback_and_command_unit mfc_checker u_mfc_checker (.*);

`default_nettype wire
